// ----- hdl/asrt_pkg.sv -----
// Shared types and constants for the array sorter.
package asrt_pkg;

   localparam int VALUE_W = 32;

   typedef logic signed [VALUE_W-1:0] value_type;

   // Per-cycle command broadcast to every cell of the chain.
   typedef struct packed {
      logic load;   // insert the incoming value at its ordered place
      logic shift;  // move every entry one cell toward the head
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

endpackage

// ----- hdl/array_sorter.sv -----
// Top level of the array sorter: insertion chain, drain control, output register.
//
// Usage:
//   Input channel (req_): one signed 32-bit value per item; req_last marks the
//   final item of a set. Each accepted value drops straight into its sorted
//   place in a chain of DEPTH cells. Values arriving while all DEPTH cells are
//   full are discarded and the run is flagged with rsp_dropped on every one of
//   its results.
//   Result channel (rsp_): after the last item, the set is shifted out of the
//   head of the chain in ascending order, one item per cycle while not stalled,
//   with rsp_last_res on the final one. rsp_valid rises once the state register
//   has entered draining and the head has been popped into the output register.
//   While draining, req_stall is high; the next set is accepted from the cycle
//   after the final result enters the output register.
//   Stalls: a high rsp_stall holds a valid result in the output register and freezes the chain while draining.
//   Reset (synchronous, active high): empties the chain, clears the drop flag
//   and the output valid; the block accepts items in the next cycle.
//   Rate is set by the chain: one compare per cell per cycle on load, one
//   shift per cycle on drain unless a stalled result holds it.
module array_sorter #(
   parameter int DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  asrt_pkg::value_type req_value,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output asrt_pkg::value_type rsp_value_res,
   output logic                rsp_last_res,
   output logic                rsp_dropped
);
   import asrt_pkg::*;

   state_type     state_ff, state_in;
   logic          overflow_ff, overflow_in;
   logic          rsp_valid_ff, rsp_valid_in;
   value_type     rsp_value_ff, rsp_value_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_drop_ff, rsp_drop_in;

   cell_ctrl_type ctrl;
   value_type     cell_value [DEPTH];
   logic          cell_occ   [DEPTH];
   logic          cell_lt    [DEPTH];

   logic          accept;
   logic          full;
   logic          pop;
   logic          pop_final;

   // ---- cell chain ----
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      value_type prev_value, next_value;
      logic      prev_lt, prev_occ, next_occ;

      if (i == 0) begin : g_head
         assign prev_lt    = 1'b0;
         assign prev_occ   = 1'b1;
         assign prev_value = req_value;
      end else begin : g_body
         assign prev_lt    = cell_lt[i-1];
         assign prev_occ   = cell_occ[i-1];
         assign prev_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_occ   = 1'b0;
         assign next_value = '0;
      end else begin : g_mid
         assign next_occ   = cell_occ[i+1];
         assign next_value = cell_value[i+1];
      end

      asrt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_value  (req_value),
         .prev_lt    (prev_lt),
         .prev_occ   (prev_occ),
         .prev_value (prev_value),
         .next_occ   (next_occ),
         .next_value (next_value),
         .value      (cell_value[i]),
         .occ        (cell_occ[i]),
         .lt         (cell_lt[i])
      );
   end

   // ---- control ----
   assign req_stall = (state_ff == ST_DRAIN);
   assign accept    = req_valid && !req_stall;
   assign full      = cell_occ[DEPTH-1];
   assign pop       = (state_ff == ST_DRAIN) && (!rsp_valid_ff || !rsp_stall);
   assign pop_final = pop && !cell_occ[1];   // head is the last stored entry

   assign ctrl.load  = accept && !full;
   assign ctrl.shift = pop;

   always_comb begin
      state_in    = state_ff;
      overflow_in = overflow_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && full) begin
               overflow_in = 1'b1;
            end
            if (accept && req_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pop_final) begin
               state_in    = ST_LOAD;
               overflow_in = 1'b0;
            end
         end
         default: begin
            state_in    = ST_LOAD;
            overflow_in = 1'b0;
         end
      endcase
   end

   // ---- output register ----
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_drop_in  = rsp_drop_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = cell_value[0];
         rsp_last_in  = !cell_occ[1];
         rsp_drop_in  = overflow_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_res = rsp_value_ff;
   assign rsp_last_res  = rsp_last_ff;
   assign rsp_dropped   = rsp_drop_ff;

`ifndef SYNTHESIS
   // a run is never empty, so the head cell holds data throughout draining
   a_drain_head_occ: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> cell_occ[0])
      else $error("draining with empty head cell");

   // occupancy stays packed at the head: an empty head means an empty second cell
   a_head_packed: assert property (@(posedge clock) disable iff (reset)
      !cell_occ[0] |-> !cell_occ[1])
      else $error("chain occupancy has a hole at the head");

   // the final pop empties the chain and returns to loading
   a_final_pop: assert property (@(posedge clock) disable iff (reset)
      pop_final |=> (state_ff == ST_LOAD) && !cell_occ[0] && !overflow_ff)
      else $error("chain not empty after final result");

   // no insertion while the chain is draining
   a_no_load_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> !ctrl.load)
      else $error("load during drain");
`endif

endmodule

// ----- hdl/asrt_cell.sv -----
// One compare-and-shift cell of the insertion chain.
module asrt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  asrt_pkg::cell_ctrl_type ctrl,
   input  asrt_pkg::value_type     new_value,
   input  logic                    prev_lt,
   input  logic                    prev_occ,
   input  asrt_pkg::value_type     prev_value,
   input  logic                    next_occ,
   input  asrt_pkg::value_type     next_value,
   output asrt_pkg::value_type     value,
   output logic                    occ,
   output logic                    lt
);
   import asrt_pkg::*;

   value_type value_ff, value_in;
   logic      occ_ff, occ_in;

   // Empty cells always count as "new value goes at or before me".
   assign lt = !occ_ff || (new_value < value_ff);

   always_comb begin
      value_in = value_ff;
      occ_in   = occ_ff;
      if (ctrl.shift) begin
         value_in = next_value;
         occ_in   = next_occ;
      end else if (ctrl.load) begin
         if (lt) begin
            // upstream neighbor also moves right: take its value, else take new one
            value_in = prev_lt ? prev_value : new_value;
         end
         occ_in = occ_ff | prev_occ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign occ   = occ_ff;

endmodule

// ----- tb/sv/array_sorter_tb.sv -----
// Testbench for array_sorter: sorted-run prediction, paced traffic and back-pressure.
`timescale 1ns / 100ps

module array_sorter_tb;
   import asrt_pkg::*;

   localparam int DEPTH          = 64;
   localparam int HOLDOFF_CYCLES = 300;   // long receiver hold-off
   localparam int IDLE_LIMIT     = 2000;  // cycles with no handshake before giving up
   localparam int SETTLE_CYCLES  = 20;    // quiet time once nothing is outstanding
   localparam int RANDOM_ITEMS   = 40;
   localparam int PRINT_LIMIT    = 100;

   // Value mixes for generated sets.
   typedef enum int {
      SPREAD_FULL,    // any 32-bit pattern
      SPREAD_NARROW,  // small range, many equal values
      SPREAD_EDGES    // extremes and values next to them
   } spread_type;

   // One sorted result as the block should emit it.
   typedef struct {
      value_type value;
      logic      is_last;
      logic      lost;
   } sorted_item_type;

   logic      clock     = 1'b0;
   logic      reset     = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   value_type req_value = '0;
   logic      req_last  = 1'b0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   value_type rsp_value_res;
   logic      rsp_last_res;
   logic      rsp_dropped;

   // Predictor state: the open set kept in ascending order, and its drop flag.
   value_type       open_set[$];
   logic            open_set_lost = 1'b0;
   sorted_item_type sorted_pending[$];   // results still owed by the block

   int   mismatches   = 0;
   int   items_sent   = 0;
   int   burst_left   = 1;
   int   idle_cycles  = 0;
   logic holdoff_req  = 1'b0;

   array_sorter #(.DEPTH(DEPTH)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value_res (rsp_value_res),
      .rsp_last_res  (rsp_last_res),
      .rsp_dropped   (rsp_dropped)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_LIMIT) begin
         $display("MISMATCH @%0t: %s", $time, what);
      end
      mismatches++;
   endtask

   // Insert an accepted value into the open set; on the closing item, queue the
   // whole run. A value that finds the store full is lost and flags the run.
   function automatic void track_sorted_insert(input value_type v, input logic is_last);
      int              pos;
      sorted_item_type item;
      if (open_set.size() < DEPTH) begin
         pos = open_set.size();
         // Stop at the first entry not greater: equal values keep arrival order.
         while (pos > 0 && v < open_set[pos-1]) begin
            pos--;
         end
         open_set.insert(pos, v);
      end else begin
         open_set_lost = 1'b1;
      end
      if (is_last) begin
         foreach (open_set[i]) begin
            item.value   = open_set[i];
            item.is_last = (i == open_set.size() - 1);
            item.lost    = open_set_lost;
            sorted_pending.push_back(item);
         end
         open_set.delete();
         open_set_lost = 1'b0;
      end
   endfunction

   // Sender pacing: bursts of random length, separated by random gaps.
   // Valid stays high across a burst so back-to-back items are offered.
   task automatic pace_sender();
      int gap;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Offer one item and hold it until the block takes it. Called at a rising edge.
   task automatic send_item(input value_type v, input logic is_last);
      req_valid <= 1'b1;
      req_value <= v;
      req_last  <= is_last;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      track_sorted_insert(v, is_last);
      items_sent++;
      pace_sender();
   endtask

   function automatic value_type pick_value(input spread_type spread);
      value_type v;
      case (spread)
         SPREAD_NARROW: begin
            v = value_type'($urandom_range(0, 8) - 4);
         end
         SPREAD_EDGES: begin
            case ($urandom_range(0, 6))
               0: v = 32'sh8000_0000;
               1: v = 32'sh8000_0001;
               2: v = 32'sh7FFF_FFFF;
               3: v = 32'sh7FFF_FFFE;
               4: v = 32'sh0000_0000;
               5: v = 32'shFFFF_FFFF;
               default: v = 32'sh0000_0001;
            endcase
         end
         default: begin
            v = $urandom;
         end
      endcase
      return v;
   endfunction

   task automatic send_random_set(input int count, input spread_type spread);
      for (int k = 0; k < count; k++) begin
         send_item(pick_value(spread), k == count - 1);
      end
   endtask

   // Stop offering items and let every owed result come out.
   task automatic settle_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sorted_pending.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests

   // One-item sets at the range limits and around zero; each emits a single result marked last.
   task automatic test_single_item_sets();
      send_item(32'sh8000_0000, 1'b1);
      send_item(32'sh7FFF_FFFF, 1'b1);
      send_item(32'sh0000_0000, 1'b1);
      send_item(32'shFFFF_FFFF, 1'b1);
   endtask

   // Extremes and repeats in one set: signed order and duplicates kept.
   task automatic test_extremes_and_repeats();
      send_item(32'sh7FFF_FFFF, 1'b0);
      send_item(32'sh8000_0000, 1'b0);
      send_item(32'sh0000_0000, 1'b0);
      send_item(32'shFFFF_FFFF, 1'b0);
      send_item(32'sh0000_0001, 1'b0);
      send_item(32'sh7FFF_FFFF, 1'b0);
      send_item(32'sh8000_0000, 1'b0);
      send_item(32'sh0000_0001, 1'b1);
   endtask

   // Already ascending and fully reversed input orders.
   task automatic test_presorted_orders();
      for (int k = -2; k <= 2; k++) begin
         send_item(k * 1000, k == 2);
      end
      for (int k = 2; k >= -2; k--) begin
         send_item(k * 1000, k == -2);
      end
   endtask

   // Store full: an exact fit, then extra values dropped including the closing item.
   task automatic test_store_full();
      send_random_set(DEPTH, SPREAD_FULL);
      send_random_set(DEPTH + 2, SPREAD_NARROW);
   endtask

   // Receiver holds off while the sender keeps offering: the output register and
   // chain freeze mid-drain and the block stalls its input.
   task automatic test_backpressure();
      holdoff_req = 1'b1;
      send_random_set(12, SPREAD_FULL);
      send_random_set(8, SPREAD_NARROW);
   endtask

   // Sender goes quiet until everything is out, then restarts on an idle block.
   task automatic test_pause_when_drained();
      send_random_set(6, SPREAD_EDGES);
      settle_results();
      send_random_set(3, SPREAD_NARROW);
   endtask

   // Random sets: mostly short, a few near or past the store size.
   task automatic test_random_sets();
      int         stop_at;
      int         count;
      spread_type spread;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0) begin
            count = $urandom_range(DEPTH - 4, DEPTH + 6);
         end else begin
            count = $urandom_range(1, 12);
         end
         case ($urandom_range(0, 3))
            0: spread = SPREAD_NARROW;
            1: spread = SPREAD_EDGES;
            default: spread = SPREAD_FULL;
         endcase
         send_random_set(count, spread);
      end
   endtask

   // ------------------------------------------------------ receiver pacing

   // Stall pattern in stretches: free-running, coin-flip, or mostly stalled.
   // A hold-off request overrides it with a long unbroken stall.
   initial begin : rsp_pacing
      int mode;
      int span;
      @(posedge clock);
      forever begin
         if (holdoff_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            holdoff_req = 1'b0;
         end else begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(1, 30);
            while (span > 0 && !holdoff_req) begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= 1'($urandom_range(0, 1));
                  default: rsp_stall <= ($urandom_range(0, 3) != 0);
               endcase
               @(posedge clock);
               span--;
            end
         end
      end
   end

   // ------------------------------------------------------------- checking

   always @(posedge clock) begin : check_results
      sorted_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sorted_pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %0d", rsp_value_res));
         end else begin
            want = sorted_pending.pop_front();
            if (rsp_value_res !== want.value) begin
               report_mismatch($sformatf("value %0d, want %0d", rsp_value_res, want.value));
            end
            if (rsp_last_res !== want.is_last) begin
               report_mismatch($sformatf("last_res %b, want %b", rsp_last_res, want.is_last));
            end
            if (rsp_dropped !== want.lost) begin
               report_mismatch($sformatf("dropped %b, want %b", rsp_dropped, want.lost));
            end
         end
      end
   end

   // Watchdog: counts cycles without a handshake on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
      end
      $display("array_sorter verification failed");
      $finish;
   end

   // --------------------------------------------------------------- main

   initial begin : run_tests
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_single_item_sets();
      test_extremes_and_repeats();
      test_presorted_orders();
      test_store_full();
      test_backpressure();
      test_pause_when_drained();
      test_random_sets();

      settle_results();
      if (mismatches == 0) begin
         $display("array_sorter verification clean");
      end else begin
         $display("array_sorter verification failed");
      end
      $finish;
   end

endmodule
